// ----- rtl/hsps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsps_pkg: shared types, constants and helpers for the peak search core
// Field widths, stream packing widths, phase and status codes, clamp and
// magnitude helpers.
// ----------------------------------------------------------------------------
package hsps_pkg;

  localparam int TUNE_BITS  = 12;
  localparam int POWER_BITS = 16;

  localparam int IN_DATA_BITS  = ((2 * TUNE_BITS + POWER_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((TUNE_BITS + POWER_BITS + 7) / 8) * 8;
  localparam int SUM_BITS      = TUNE_BITS + 2;

  typedef logic [TUNE_BITS-1:0]         tune_t;
  typedef logic signed [POWER_BITS-1:0] power_t;
  typedef logic [POWER_BITS:0]          mag_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_MEASURE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_PROBE   = 2'd0,
    ST_DONE    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SEARCH = 2'd2
  } phase_t;

  localparam tune_t TUNE_MAX = {TUNE_BITS{1'b1}};

  function automatic tune_t clamp_tune(input sum_t v);
    tune_t res;
    if (v < 0) begin
      res = '0;
    end else if (v > sum_t'({2'b00, TUNE_MAX})) begin
      res = TUNE_MAX;
    end else begin
      res = v[TUNE_BITS-1:0];
    end
    return res;
  endfunction

  function automatic mag_t power_mag(input power_t v);
    logic signed [POWER_BITS:0] ext;
    mag_t res;
    ext = {v[POWER_BITS-1], v};
    if (v[POWER_BITS-1]) begin
      res = mag_t'(-ext);
    end else begin
      res = mag_t'(ext);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/halving_step_peak_search_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// halving_step_peak_search_core: tuning peak search with halving step
// Start beats load origin and span and return the first probe tune;
// measurement beats return the next probe or the final best tune, or are ignored while idle.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects start (0) or measurement (1); in_tdata
//   carries start tune, span and the power sample taken at the last probe.
//   Result stream: one beat per input beat; out_tuser is the status
//   (probe, done, ignored), out_tdata the tune word and best power.
//   Path: input register, then result register, from input beat to result
//   beat. Throughput: one beat per cycle while the receiver takes results,
//   set by the single compare/add/clamp path between the two registers,
//   which also updates the search state.
//   Reset (rst_n low, synchronous): both stages empty, search idle; origin,
//   probe and best tunes, step and best power zero.
//   Receiver stall: the result register holds its beat; one more input
//   beat is taken into the input register, then in_tready drops until the
//   result beat is taken.
// ----------------------------------------------------------------------------
module halving_step_peak_search_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // lowest bit up: start_tune, search_span, power_reading
  input  wire [hsps_pkg::IN_DATA_BITS-1:0] in_tdata,
  // opcode
  input  wire [0:0]                        in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // lowest bit up: tune_word, best_power, zero fill
  output logic [hsps_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // status
  output logic [1:0]                       out_tuser
);
  import hsps_pkg::*;

  logic    in_valid_r;
  opcode_t in_op_r;
  tune_t   in_start_r;
  tune_t   in_span_r;
  power_t  in_power_r;

  phase_t  phase_r, phase_nxt;
  tune_t   step_r, step_nxt;
  tune_t   origin_r, origin_nxt;
  tune_t   best_tune_r, best_tune_nxt;
  power_t  best_level_r, best_level_nxt;
  tune_t   probe_r, probe_nxt;

  logic    out_valid_r;
  tune_t   out_tune_r, out_tune_nxt;
  status_t out_status_r, out_status_nxt;
  power_t  out_power_r;

  logic    advance;
  logic    dir_up;
  logic    better;
  tune_t   new_best;
  tune_t   half_step;
  sum_t    start_sum;
  sum_t    first_sum;
  sum_t    search_sum;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r    <= opcode_t'(in_tuser[0]);
      in_start_r <= in_tdata[TUNE_BITS-1:0];
      in_span_r  <= in_tdata[2*TUNE_BITS-1:TUNE_BITS];
      in_power_r <= in_tdata[2*TUNE_BITS+POWER_BITS-1:2*TUNE_BITS];
    end
  end

  assign dir_up     = probe_r > best_tune_r;
  assign better     = power_mag(in_power_r) > power_mag(best_level_r);
  assign new_best   = better ? probe_r : best_tune_r;
  assign half_step  = step_r >> 1;
  assign start_sum  = sum_t'({2'b00, in_start_r}) - sum_t'({2'b00, in_span_r});
  assign first_sum  = sum_t'({2'b00, origin_r}) + sum_t'({2'b00, step_r});
  assign search_sum = (better ^ dir_up) ?
                      sum_t'({2'b00, new_best}) + sum_t'({2'b00, step_r}) :
                      sum_t'({2'b00, new_best}) - sum_t'({2'b00, step_r});

  always_comb begin
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    origin_nxt     = origin_r;
    best_tune_nxt  = best_tune_r;
    best_level_nxt = best_level_r;
    probe_nxt      = probe_r;
    out_tune_nxt   = best_tune_r;
    out_status_nxt = ST_IGNORED;
    if (in_op_r == OP_START) begin
      origin_nxt     = in_start_r;
      step_nxt       = in_span_r;
      probe_nxt      = clamp_tune(start_sum);
      phase_nxt      = PH_FIRST;
      out_tune_nxt   = probe_nxt;
      out_status_nxt = ST_PROBE;
    end else begin
      case (phase_r)
        PH_FIRST: begin
          best_level_nxt = in_power_r;
          best_tune_nxt  = probe_r;
          if (step_r == '0) begin
            phase_nxt      = PH_IDLE;
            out_tune_nxt   = probe_r;
            out_status_nxt = ST_DONE;
          end else begin
            probe_nxt      = clamp_tune(first_sum);
            phase_nxt      = PH_SEARCH;
            out_tune_nxt   = probe_nxt;
            out_status_nxt = ST_PROBE;
          end
        end
        PH_SEARCH: begin
          if (better) begin
            best_level_nxt = in_power_r;
            best_tune_nxt  = probe_r;
          end
          step_nxt = half_step;
          if (half_step == '0) begin
            phase_nxt      = PH_IDLE;
            out_tune_nxt   = new_best;
            out_status_nxt = ST_DONE;
          end else begin
            probe_nxt      = clamp_tune(search_sum);
            out_tune_nxt   = probe_nxt;
            out_status_nxt = ST_PROBE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // search state, advance with each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      step_r       <= '0;
      origin_r     <= '0;
      best_tune_r  <= '0;
      best_level_r <= '0;
      probe_r      <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      origin_r     <= origin_nxt;
      best_tune_r  <= best_tune_nxt;
      best_level_r <= best_level_nxt;
      probe_r      <= probe_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tune_r   <= out_tune_nxt;
      out_status_r <= out_status_nxt;
      out_power_r  <= best_level_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_BITS - TUNE_BITS - POWER_BITS){1'b0}},
                       out_power_r, out_tune_r};

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the halving-step peak search core
// Feeds start and measurement beats, first from a directed table and then
// as random search sequences with some noise and aborted searches. Every
// result beat is checked against its table expectation, where given, or an
// in-bench search tracker. Both sides idle and stall at random but in a steady run.
// ----------------------------------------------------------------------------
module tb;
  import hsps_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    tune_t   tune;
    status_t status;
    power_t  level;
  } search_result_t;

  typedef struct packed {
    opcode_t        op;
    tune_t          tune;
    tune_t          span;
    power_t         pwr;
    bit             typed;
    search_result_t want;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_DATA_BITS-1:0]   in_tdata;
  logic [0:0]                in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic [1:0]                out_tuser;

  // search tracker
  phase_t srch_phase;
  tune_t  srch_step;
  tune_t  srch_origin;
  tune_t  srch_best;
  power_t srch_level;
  tune_t  srch_probe;

  search_result_t pending_q[$];
  stim_row_t      stim_rows[$];
  search_result_t want_res;

  bit steady;
  int mismatches;
  int results_checked;
  int beats_sent;
  int searches_begun;
  int searches_done;
  int idle_cycles;

  halving_step_peak_search_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic tune_t clip_tune(input int v);
    if (v < 0) return '0;
    if (v > int'(TUNE_MAX)) return TUNE_MAX;
    return tune_t'(v);
  endfunction

  function automatic int level_mag(input power_t p);
    int v;
    v = p;
    return (v < 0) ? -v : v;
  endfunction

  task automatic advance_search(input opcode_t op, input tune_t tune, input tune_t span,
                                input power_t pwr, output search_result_t res);
    int dir;
    int nxt;
    if (op == OP_START) begin
      srch_origin = tune;
      srch_step   = span;
      srch_probe  = clip_tune(int'(tune) - int'(span));
      srch_phase  = PH_FIRST;
      searches_begun++;
      res = '{srch_probe, ST_PROBE, srch_level};
    end else if (srch_phase == PH_FIRST) begin
      srch_level = pwr;
      srch_best  = srch_probe;
      if (srch_step == 0) begin
        srch_phase = PH_IDLE;
        searches_done++;
        res = '{srch_best, ST_DONE, srch_level};
      end else begin
        srch_probe = clip_tune(int'(srch_origin) + int'(srch_step));
        srch_phase = PH_SEARCH;
        res = '{srch_probe, ST_PROBE, srch_level};
      end
    end else if (srch_phase == PH_SEARCH) begin
      dir = (srch_probe > srch_best) ? 1 : -1;
      if (level_mag(pwr) > level_mag(srch_level)) begin
        srch_level = pwr;
        srch_best  = srch_probe;
        nxt = int'(srch_best) - int'(srch_step) * dir;
      end else begin
        nxt = int'(srch_best) + int'(srch_step) * dir;
      end
      srch_step = srch_step >> 1;
      if (srch_step == 0) begin
        srch_phase = PH_IDLE;
        searches_done++;
        res = '{srch_best, ST_DONE, srch_level};
      end else begin
        srch_probe = clip_tune(nxt);
        res = '{srch_probe, ST_PROBE, srch_level};
      end
    end else begin
      srch_phase = PH_IDLE;
      res = '{srch_best, ST_IGNORED, srch_level};
    end
  endtask

  function automatic void add_row(input opcode_t op, input tune_t tune, input tune_t span,
                                  input power_t pwr, input bit typed = 1'b0,
                                  input tune_t w_tune = '0, input status_t w_status = ST_PROBE,
                                  input power_t w_level = '0);
    stim_row_t row;
    row.op    = op;
    row.tune  = tune;
    row.span  = span;
    row.pwr   = pwr;
    row.typed = typed;
    row.want  = '{w_tune, w_status, w_level};
    stim_rows.push_back(row);
  endfunction

  task automatic send_beat(input opcode_t op, input tune_t tune, input tune_t span,
                           input power_t pwr, input bit typed = 1'b0,
                           input search_result_t want = '0);
    search_result_t res;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pwr, span, tune};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    advance_search(op, tune, span, pwr, res);
    pending_q.push_back(typed ? want : res);
    beats_sent++;
  endtask

  // hold the sender off until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic tune_t pick_tune();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return TUNE_MAX;
    return tune_t'($urandom_range(0, int'(TUNE_MAX)));
  endfunction

  function automatic tune_t pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return TUNE_MAX;
    if (r < 40) return tune_t'($urandom_range(1, 8));
    return tune_t'($urandom_range(0, int'(TUNE_MAX)));
  endfunction

  function automatic power_t pick_power();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return srch_level;
    if (r < 15) return -srch_level;
    if (r < 22) return power_t'(-32768);
    if (r < 29) return power_t'(32767);
    if (r < 33) return '0;
    return power_t'($urandom);
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want, got,
               results_checked);
  endtask

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        note_mismatch("result with nothing pending, tune", -1,
                      int'(out_tdata[TUNE_BITS-1:0]));
      end else begin
        want_res = pending_q.pop_front();
        if (out_tdata[TUNE_BITS-1:0] !== want_res.tune)
          note_mismatch("tune_word", int'(want_res.tune), int'(out_tdata[TUNE_BITS-1:0]));
        if (out_tuser !== want_res.status)
          note_mismatch("status", int'(want_res.status), int'(out_tuser));
        if (out_tdata[TUNE_BITS +: POWER_BITS] !== want_res.level)
          note_mismatch("best_power", int'(want_res.level),
                        int'(power_t'(out_tdata[TUNE_BITS +: POWER_BITS])));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("halving_step_peak_search_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    int busy_items;
    bit drained_mid;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    steady      = 1'b0;
    mismatches  = 0;
    results_checked = 0;
    beats_sent  = 0;
    searches_begun = 0;
    searches_done  = 0;
    idle_cycles = 0;
    busy_items  = 0;
    drained_mid = 1'b0;
    srch_phase  = PH_IDLE;
    srch_step   = '0;
    srch_origin = '0;
    srch_best   = '0;
    srch_level  = '0;
    srch_probe  = '0;

    // measurement while idle, full span from zero, extreme readings
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sh7FFF, 1'b1, 12'd0, ST_IGNORED, 16'sd0);
    add_row(OP_START, 12'd0, 12'd4095, 16'sd0, 1'b1, 12'd0, ST_PROBE, 16'sd0);
    add_row(OP_MEASURE, 12'd0, 12'd0, power_t'(-32768), 1'b1, 12'd4095, ST_PROBE,
            power_t'(-32768));
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sh7FFF);
    // restart mid-search with zero span: first reading ends the search
    add_row(OP_START, 12'd4095, 12'd0, 16'sd0, 1'b1, 12'd4095, ST_PROBE, power_t'(-32768));
    add_row(OP_MEASURE, 12'd4095, 12'd4095, 16'sd0, 1'b1, 12'd4095, ST_DONE, 16'sd0);
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sd1234, 1'b1, 12'd4095, ST_IGNORED, 16'sd0);
    // equal magnitudes count as no gain
    add_row(OP_START, 12'd2048, 12'd4, 16'sd0, 1'b1, 12'd2044, ST_PROBE, 16'sd0);
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sd100, 1'b1, 12'd2052, ST_PROBE, 16'sd100);
    add_row(OP_MEASURE, 12'd0, 12'd0, -16'sd100);
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sd200);
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sd50);
    add_row(OP_START, 12'd4095, 12'd4095, 16'sh7FFF);
    add_row(OP_MEASURE, 12'd0, 12'd0, -16'sd1);
    add_row(OP_START, 12'd1000, 12'd300, 16'sd0);
    add_row(OP_MEASURE, 12'd4095, 12'd4095, 16'sh7FFF);
    add_row(OP_MEASURE, 12'd0, 12'd0, power_t'(-32768));
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sd5);
    add_row(OP_MEASURE, 12'd0, 12'd0, -16'sd7);
    add_row(OP_START, 12'd4095, 12'd1, 16'sd0);
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sd10);
    add_row(OP_MEASURE, 12'd0, 12'd0, -16'sd20);
    add_row(OP_MEASURE, 12'd0, 12'd0, 16'sd30);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i])
      send_beat(stim_rows[i].op, stim_rows[i].tune, stim_rows[i].span, stim_rows[i].pwr,
                stim_rows[i].typed, stim_rows[i].want);
    drain_results();
    busy_items = stim_rows.size();

    while (busy_items < ITEM_TARGET) begin
      steady = (busy_items >= 450 && busy_items < 700);
      if (!drained_mid && busy_items >= 900) begin
        drain_results();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 99) < 6) begin
        if (srch_phase != PH_IDLE) busy_items++;
        send_beat(OP_MEASURE, pick_tune(), pick_tune(), pick_power());
      end else begin
        send_beat(OP_START, pick_tune(), pick_span(), pick_power());
        busy_items++;
        // a few searches are cut short by the next start
        while (srch_phase != PH_IDLE && $urandom_range(0, 99) >= 3) begin
          send_beat(OP_MEASURE, pick_tune(), pick_tune(), pick_power());
          busy_items++;
        end
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d beats sent, %0d results checked, %0d mismatches", beats_sent,
             results_checked, mismatches);
    $display("%0d searches started, %0d ran to a final tune", searches_begun, searches_done);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("halving_step_peak_search_core verification clean");
    end else begin
      $display("halving_step_peak_search_core verification failed");
    end
    $finish;
  end

endmodule
